[hdl/c8fc_pkg.sv]
// shared constants, status codes and the crc-8 byte update for the frame checker
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps

package c8fc_pkg;

    localparam int FRAME_BYTES   = 32;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 6;
    localparam int POS_W         = $clog2(FRAME_BYTES);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_BAD_END   = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_END   = 3'd1;
    localparam logic [2:0] REG_LEFT  = 3'd2;
    localparam logic [2:0] REG_RIGHT = 3'd3;

    typedef logic [7:0] byte_t;

    // failure flags gathered over one frame
    typedef struct packed {
        logic crc_bad;
        logic end_bad;
        logic type_bad;
        logic start_bad;
    } fail_t;

    // msb-first crc-8 update over one byte
    function automatic byte_t crc8_feed(input byte_t acc, input byte_t b);
        byte_t c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/c8fc_cell.sv]
// one byte cell of the payload shift chain
// depends on c8fc_pkg
`timescale 1ns / 1ps

module c8fc_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  c8fc_pkg::byte_t din,
    output c8fc_pkg::byte_t dout
);

    c8fc_pkg::byte_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

[hdl/c8fc_chain.sv]
// row of byte cells holding the payload, fed at the tail and read at the head
// depends on c8fc_pkg and c8fc_cell
`timescale 1ns / 1ps

module c8fc_chain (
    input  logic            aclk,
    input  logic            shift_en,
    input  c8fc_pkg::byte_t din,
    output c8fc_pkg::byte_t head
);

    c8fc_pkg::byte_t q [c8fc_pkg::PAYLOAD_BYTES];

    for (genvar i = 0; i < c8fc_pkg::PAYLOAD_BYTES; i++) begin : g_cell
        c8fc_pkg::byte_t cell_in;
        if (i == c8fc_pkg::PAYLOAD_BYTES - 1) begin : g_tail
            assign cell_in = din;
        end else begin : g_mid
            assign cell_in = q[i + 1];
        end
        c8fc_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .din      (cell_in),
            .dout     (q[i])
        );
    end

    assign head = q[0];

endmodule

[hdl/crc8_frame_checker.sv]
// top level of the crc-8 framed packet checker
// depends on c8fc_pkg and c8fc_chain
`timescale 1ns / 1ps

// Frame checker: takes one frame byte per input transaction (start, type,
// little-endian sequence, payload, crc-8, end). The crc-8 (poly 0x07, init
// 0xFF, msb first) over bytes 1 to FRAME_BYTES-3 is updated in the same
// cycle a byte is accepted. Payload bytes shift into a row of byte cells;
// when the end byte is accepted a good frame shifts its 26 payload bytes
// out of the head of that row, one result transaction per cycle while
// m_ready is high, and a bad frame gives one error result. s_ready stays
// low while results are pending, so no byte of the next frame is taken
// until every result of the current frame has been taken.
// s_frame_start forces the byte to be byte 0 and drops any partial frame.
// Configuration writes are taken at any time (cfg_ready is always high) but
// must only be issued while the block is idle; indexes beyond 3 are ignored.
module crc8_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // byte input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_frame_kind,
    output logic [15:0] m_sequence_res,
    output logic [4:0]  m_payload_index,
    output logic [7:0]  m_payload_value,
    output logic        m_last_of_frame
);

    localparam int POS_W = c8fc_pkg::POS_W;
    localparam int IDX_W = c8fc_pkg::IDX_W;

    // configuration registers
    c8fc_pkg::byte_t start_val_reg, end_val_reg, left_code_reg, right_code_reg;

    // frame tracking state
    logic [POS_W-1:0] pos_reg, pos_next;
    c8fc_pkg::byte_t  crc_reg, crc_next;
    logic [15:0]      seq_reg, seq_next;
    logic             kind_reg, kind_next;
    c8fc_pkg::fail_t  fail_reg, fail_next;

    // result side
    logic             out_valid_reg;
    logic [2:0]       out_status_reg;
    logic             out_kind_reg;
    logic [15:0]      out_seq_reg;
    logic [IDX_W-1:0] out_idx_reg;

    logic             s_fire, m_fire, cfg_fire;
    logic [POS_W-1:0] pos_cur;
    logic             shift_in, judge;
    logic [2:0]       status_next;
    logic             chain_shift;
    c8fc_pkg::byte_t  chain_head;
    logic             burst_last;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_ready   = ~out_valid_reg;
    assign s_fire    = s_valid & s_ready;
    assign m_fire    = out_valid_reg & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_val_reg  <= 8'hAA;
            end_val_reg    <= 8'h55;
            left_code_reg  <= 8'h01;
            right_code_reg <= 8'h02;
        end else if (cfg_fire) begin
            case (cfg_index)
                c8fc_pkg::REG_START: start_val_reg  <= cfg_data;
                c8fc_pkg::REG_END:   end_val_reg    <= cfg_data;
                c8fc_pkg::REG_LEFT:  left_code_reg  <= cfg_data;
                c8fc_pkg::REG_RIGHT: right_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte frame decode
    always_comb begin
        pos_cur   = s_frame_start ? '0 : pos_reg;
        crc_next  = crc_reg;
        seq_next  = seq_reg;
        kind_next = kind_reg;
        fail_next = fail_reg;
        shift_in  = 1'b0;
        judge     = 1'b0;

        if (pos_cur == '0) begin
            // start byte, clears the frame state
            crc_next            = c8fc_pkg::CRC_INIT;
            seq_next            = '0;
            kind_next           = 1'b0;
            fail_next           = '0;
            fail_next.start_bad = (s_rx_byte != start_val_reg);
        end else if (pos_cur == POS_W'(1)) begin
            crc_next = c8fc_pkg::crc8_feed(crc_reg, s_rx_byte);
            // equal codes resolve to left
            if (s_rx_byte == left_code_reg) begin
                kind_next = 1'b0;
            end else if (s_rx_byte == right_code_reg) begin
                kind_next = 1'b1;
            end else begin
                fail_next.type_bad = 1'b1;
            end
        end else if (pos_cur == POS_W'(2)) begin
            crc_next = c8fc_pkg::crc8_feed(crc_reg, s_rx_byte);
            seq_next = {seq_reg[15:8], s_rx_byte};
        end else if (pos_cur == POS_W'(3)) begin
            crc_next = c8fc_pkg::crc8_feed(crc_reg, s_rx_byte);
            seq_next = {s_rx_byte, seq_reg[7:0]};
        end else if (pos_cur < POS_W'(c8fc_pkg::FRAME_BYTES - 2)) begin
            // payload byte enters the tail of the cell row
            crc_next = c8fc_pkg::crc8_feed(crc_reg, s_rx_byte);
            shift_in = 1'b1;
        end else if (pos_cur == POS_W'(c8fc_pkg::FRAME_BYTES - 2)) begin
            fail_next.crc_bad = (s_rx_byte != crc_reg);
        end else begin
            fail_next.end_bad = (s_rx_byte != end_val_reg);
            judge             = 1'b1;
        end

        pos_next = (pos_cur == POS_W'(c8fc_pkg::FRAME_BYTES - 1)) ? '0 : pos_cur + 1'b1;

        // first failing check in order start, type, end, crc
        if (fail_next.start_bad) begin
            status_next = c8fc_pkg::ST_BAD_START;
        end else if (fail_next.type_bad) begin
            status_next = c8fc_pkg::ST_BAD_TYPE;
        end else if (fail_next.end_bad) begin
            status_next = c8fc_pkg::ST_BAD_END;
        end else if (fail_next.crc_bad) begin
            status_next = c8fc_pkg::ST_BAD_CRC;
        end else begin
            status_next = c8fc_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= c8fc_pkg::CRC_INIT;
            seq_reg  <= '0;
            kind_reg <= 1'b0;
            fail_reg <= '0;
        end else if (s_fire) begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            seq_reg  <= seq_next;
            kind_reg <= kind_next;
            fail_reg <= fail_next;
        end
    end

    assign burst_last = (out_idx_reg == IDX_W'(c8fc_pkg::PAYLOAD_BYTES - 1));

    // result sequencing: one error result, or a burst walking the cell row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire && judge) begin
            out_valid_reg <= 1'b1;
        end else if (m_fire && (out_status_reg != c8fc_pkg::ST_OK || burst_last)) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && judge) begin
            out_status_reg <= status_next;
            out_idx_reg    <= '0;
            if (status_next == c8fc_pkg::ST_OK) begin
                out_kind_reg <= kind_next;
                out_seq_reg  <= seq_next;
            end else begin
                out_kind_reg <= 1'b0;
                out_seq_reg  <= '0;
            end
        end else if (m_fire) begin
            out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    assign chain_shift = (s_fire && shift_in) ||
                         (m_fire && out_status_reg == c8fc_pkg::ST_OK);

    c8fc_chain u_chain (
        .aclk     (aclk),
        .shift_en (chain_shift),
        .din      (s_rx_byte),
        .head     (chain_head)
    );

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_frame_kind    = out_kind_reg;
    assign m_sequence_res  = out_seq_reg;
    assign m_payload_index = 5'(out_idx_reg);
    assign m_payload_value = (out_status_reg == c8fc_pkg::ST_OK) ? chain_head : 8'h00;
    assign m_last_of_frame = (out_status_reg != c8fc_pkg::ST_OK) || burst_last;

    // burst index stays inside the payload
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_idx_reg <= IDX_W'(c8fc_pkg::PAYLOAD_BYTES - 1))
        else $error("payload index beyond payload");

    // an error result is a single marked result with no payload
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != c8fc_pkg::ST_OK) |->
        (m_last_of_frame && m_payload_value == 8'h00 && out_idx_reg == '0))
        else $error("malformed error result");

    // the final result of a frame ends the burst
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last_of_frame) |=> !out_valid_reg)
        else $error("results continue after last of frame");

    // accepting the end byte always produces a result
    a_judge_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && judge) |=> (out_valid_reg && out_idx_reg == '0))
        else $error("frame judged without a result");

endmodule

[sim/tb_crc8_frame_checker.sv]
// self-checking testbench for crc8_frame_checker: directed frames from a table, then random frames
// depends on c8fc_pkg and rtl under hdl; checks every result against predictor or typed status
`timescale 1ns / 1ps

module tb_crc8_frame_checker;

    // idle chance per side in percent, drain pause before config writes, stall limit
    localparam int IDLE_PCT       = 9;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // an index outside the register file, the block must ignore it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // fault masks used when building frames
    localparam c8fc_pkg::fail_t F_NONE  = 4'b0000;
    localparam c8fc_pkg::fail_t F_START = 4'b0001;
    localparam c8fc_pkg::fail_t F_TYPE  = 4'b0010;
    localparam c8fc_pkg::fail_t F_END   = 4'b0100;
    localparam c8fc_pkg::fail_t F_CRC   = 4'b1000;

    // one result transaction as the block emits it
    typedef struct packed {
        logic [2:0]      status;
        logic            kind;
        logic [15:0]     seq;
        logic [4:0]      idx;
        c8fc_pkg::byte_t val;
        logic            last;
    } frame_res_t;

    // one byte transaction, with an optional hand-written error status for the end byte
    typedef struct packed {
        c8fc_pkg::byte_t rx;
        logic            sof;
        logic            typed;
        logic [2:0]      typed_st;
    } rx_item_t;

    // one row of the directed table: a whole frame, or the first cut bytes of one
    typedef struct {
        c8fc_pkg::fail_t flt;
        logic            right;
        logic [15:0]     seq;
        c8fc_pkg::byte_t fill;
        c8fc_pkg::byte_t step;
        int              cut;
        logic            sof;
        logic [2:0]      st;
    } frame_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = c8fc_pkg::REG_START;
    logic [7:0]  cfg_data      = 8'h00;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte     = 8'h00;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic        m_frame_kind;
    logic [15:0] m_sequence_res;
    logic [4:0]  m_payload_index;
    logic [7:0]  m_payload_value;
    logic        m_last_of_frame;

    crc8_frame_checker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_kind    (m_frame_kind),
        .m_sequence_res  (m_sequence_res),
        .m_payload_index (m_payload_index),
        .m_payload_value (m_payload_value),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // configuration copy, follows every accepted register write
    c8fc_pkg::byte_t cfg_start = 8'hAA;
    c8fc_pkg::byte_t cfg_end   = 8'h55;
    c8fc_pkg::byte_t cfg_left  = 8'h01;
    c8fc_pkg::byte_t cfg_right = 8'h02;

    // frame tracker state
    int unsigned     fr_pos  = 0;
    c8fc_pkg::byte_t fr_crc  = c8fc_pkg::CRC_INIT;
    c8fc_pkg::byte_t pay_buf [c8fc_pkg::PAYLOAD_BYTES];
    logic [15:0]     fr_seq  = 16'h0000;
    logic            fr_kind = 1'b0;
    c8fc_pkg::fail_t fr_fail = F_NONE;

    frame_res_t fresh[$];          // results caused by the byte just taken
    frame_res_t pending[$];        // results still owed by the block
    rx_item_t   byte_fifo[$];      // bytes waiting to be offered
    rx_item_t   cur_item;          // byte on the input port right now

    int idle_pct     = IDLE_PCT;
    int fail_count   = 0;
    int pushed_bytes = 0;
    int quiet_cycles = 0;

    // directed frames, all at the reset register values; typed status only on error frames
    frame_row_t dir_rows [0:5] = '{
        '{F_NONE,                 1'b0, 16'h0000, 8'h00, 8'h00, 0,  1'b1, c8fc_pkg::ST_OK},
        // frame dropped part way, the next row resyncs
        '{F_NONE,                 1'b0, 16'h00FF, 8'h11, 8'h00, 10, 1'b1, c8fc_pkg::ST_OK},
        // several faults: start wins, then type, then end
        '{F_START | F_TYPE,       1'b0, 16'h0001, 8'h5A, 8'h00, 0,  1'b1,
          c8fc_pkg::ST_BAD_START},
        '{F_TYPE | F_END | F_CRC, 1'b1, 16'h0002, 8'hA5, 8'h00, 0,  1'b1,
          c8fc_pkg::ST_BAD_TYPE},
        // no frame_start: position wraps after the previous frame
        '{F_END | F_CRC,          1'b1, 16'h0003, 8'h3C, 8'h01, 0,  1'b0,
          c8fc_pkg::ST_BAD_END},
        '{F_CRC,                  1'b0, 16'h0004, 8'hC3, 8'h00, 0,  1'b1,
          c8fc_pkg::ST_BAD_CRC}
    };

    // crc-8 fed one data bit at a time, msb first
    function automatic c8fc_pkg::byte_t crc_next(input c8fc_pkg::byte_t acc,
                                                 input c8fc_pkg::byte_t b);
        c8fc_pkg::byte_t r;
        logic            fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ c8fc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // advance the frame tracker by one accepted byte, results land in fresh
    task automatic absorb_byte(input c8fc_pkg::byte_t b, input logic sof);
        int unsigned pos;
        logic [2:0]  st;
        pos = sof ? 0 : fr_pos;
        if (pos >= c8fc_pkg::FRAME_BYTES) begin
            pos = 0;
        end
        fresh.delete();
        if (pos == 0) begin
            fr_fail           = F_NONE;
            fr_crc            = c8fc_pkg::CRC_INIT;
            fr_seq            = 16'h0000;
            fr_kind           = 1'b0;
            fr_fail.start_bad = (b != cfg_start);
        end else if (pos == 1) begin
            fr_crc = crc_next(fr_crc, b);
            // equal codes resolve to left
            if (b == cfg_left) begin
                fr_kind = 1'b0;
            end else if (b == cfg_right) begin
                fr_kind = 1'b1;
            end else begin
                fr_fail.type_bad = 1'b1;
            end
        end else if (pos == 2) begin
            fr_crc      = crc_next(fr_crc, b);
            fr_seq[7:0] = b;
        end else if (pos == 3) begin
            fr_crc       = crc_next(fr_crc, b);
            fr_seq[15:8] = b;
        end else if (pos < c8fc_pkg::FRAME_BYTES - 2) begin
            fr_crc           = crc_next(fr_crc, b);
            pay_buf[pos - 4] = b;
        end else if (pos == c8fc_pkg::FRAME_BYTES - 2) begin
            fr_fail.crc_bad = (b != fr_crc);
        end else begin
            fr_fail.end_bad = (b != cfg_end);
            if (fr_fail == F_NONE) begin
                for (int i = 0; i < c8fc_pkg::PAYLOAD_BYTES; i++) begin
                    fresh.push_back('{c8fc_pkg::ST_OK, fr_kind, fr_seq, 5'(i), pay_buf[i],
                                      (i == c8fc_pkg::PAYLOAD_BYTES - 1)});
                end
            end else begin
                st = fr_fail.start_bad ? c8fc_pkg::ST_BAD_START :
                     fr_fail.type_bad  ? c8fc_pkg::ST_BAD_TYPE  :
                     fr_fail.end_bad   ? c8fc_pkg::ST_BAD_END   : c8fc_pkg::ST_BAD_CRC;
                fresh.push_back('{st, 1'b0, 16'h0000, 5'd0, 8'h00, 1'b1});
            end
        end
        fr_pos = (pos + 1 >= c8fc_pkg::FRAME_BYTES) ? 0 : pos + 1;
    endtask

    task automatic push_item(input c8fc_pkg::byte_t rx, input logic sof, input logic typed,
                             input logic [2:0] st);
        byte_fifo.push_back('{rx, sof, typed, st});
        pushed_bytes++;
    endtask

    // queue one frame built from the current register values, optionally cut short
    task automatic add_frame(input c8fc_pkg::fail_t flt, input logic right,
                             input logic [15:0] seq, input c8fc_pkg::byte_t fill,
                             input c8fc_pkg::byte_t step, input logic rnd_pay,
                             input int cut, input logic sof, input logic [2:0] st);
        c8fc_pkg::byte_t fb [c8fc_pkg::FRAME_BYTES];
        c8fc_pkg::byte_t acc;
        int              n;
        fb[0] = flt.start_bad ? cfg_start ^ c8fc_pkg::byte_t'($urandom_range(1, 255))
                              : cfg_start;
        if (flt.type_bad) begin
            fb[1] = c8fc_pkg::byte_t'($urandom);
            while (fb[1] == cfg_left || fb[1] == cfg_right) begin
                fb[1] = fb[1] + 8'd1;
            end
        end else begin
            fb[1] = right ? cfg_right : cfg_left;
        end
        fb[2] = seq[7:0];
        fb[3] = seq[15:8];
        for (int i = 4; i < c8fc_pkg::FRAME_BYTES - 2; i++) begin
            fb[i] = rnd_pay ? c8fc_pkg::byte_t'($urandom)
                            : fill + c8fc_pkg::byte_t'(i - 4) * step;
        end
        acc = c8fc_pkg::CRC_INIT;
        for (int i = 1; i < c8fc_pkg::FRAME_BYTES - 2; i++) begin
            acc = crc_next(acc, fb[i]);
        end
        fb[c8fc_pkg::FRAME_BYTES - 2] = flt.crc_bad ?
            acc ^ c8fc_pkg::byte_t'($urandom_range(1, 255)) : acc;
        fb[c8fc_pkg::FRAME_BYTES - 1] = flt.end_bad ?
            cfg_end ^ c8fc_pkg::byte_t'($urandom_range(1, 255)) : cfg_end;
        n = (cut != 0) ? cut : c8fc_pkg::FRAME_BYTES;
        for (int i = 0; i < n; i++) begin
            push_item(fb[i], (i == 0) ? sof : 1'b0,
                      (i == c8fc_pkg::FRAME_BYTES - 1) && (st != c8fc_pkg::ST_OK), st);
        end
    endtask

    // mostly good frames with random content, some faulty, cut or plain noise
    task automatic random_frames(input int budget);
        int              first;
        int              r;
        logic            after_break;
        c8fc_pkg::fail_t flt;
        first       = pushed_bytes;
        after_break = 1'b0;
        while (pushed_bytes - first < budget) begin
            r = $urandom_range(99);
            if (after_break || r < 70) begin
                // after a break the next frame must resync
                add_frame(F_NONE, 1'($urandom_range(1)), 16'($urandom), 8'h00, 8'h00, 1'b1, 0,
                          after_break ? 1'b1 : 1'($urandom_range(1)), c8fc_pkg::ST_OK);
                after_break = 1'b0;
            end else if (r < 85) begin
                flt = 4'($urandom_range(1, 15));
                add_frame(flt, 1'($urandom_range(1)), 16'($urandom), 8'h00, 8'h00, 1'b1, 0,
                          1'($urandom_range(1)), c8fc_pkg::ST_OK);
            end else if (r < 93) begin
                add_frame(F_NONE, 1'($urandom_range(1)), 16'($urandom), 8'h00, 8'h00, 1'b1,
                          $urandom_range(1, c8fc_pkg::FRAME_BYTES - 1), 1'b1, c8fc_pkg::ST_OK);
                after_break = 1'b1;
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    push_item(c8fc_pkg::byte_t'($urandom), 1'($urandom_range(3) == 0), 1'b0,
                              c8fc_pkg::ST_OK);
                end
                after_break = 1'b1;
            end
        end
        // close the phase on a frame boundary
        if (after_break) begin
            add_frame(F_NONE, 1'($urandom_range(1)), 16'($urandom), 8'h00, 8'h00, 1'b1, 0,
                      1'b1, c8fc_pkg::ST_OK);
        end
    endtask

    // one configuration transaction, the local copy follows at acceptance
    task automatic write_reg(input logic [2:0] idx, input c8fc_pkg::byte_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            c8fc_pkg::REG_START: cfg_start = val;
            c8fc_pkg::REG_END:   cfg_end   = val;
            c8fc_pkg::REG_LEFT:  cfg_left  = val;
            c8fc_pkg::REG_RIGHT: cfg_right = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // sender holds off until every owed result is in, then the block settles
    task automatic wait_drained();
        do @(negedge aclk); while (byte_fifo.size() != 0 || s_valid || pending.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // both channels and the watchdog, all sampled on the rising edge
    always @(posedge aclk) begin
        frame_res_t want;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            m_ready      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            // byte transaction taken: predict, or use the hand-written error status
            if (s_valid && s_ready) begin
                absorb_byte(cur_item.rx, cur_item.sof);
                if (cur_item.typed) begin
                    pending.push_back('{cur_item.typed_st, 1'b0, 16'h0000, 5'd0, 8'h00, 1'b1});
                end else begin
                    foreach (fresh[k]) begin
                        pending.push_back(fresh[k]);
                    end
                end
            end
            // offer the next byte, or idle now and then; payload holds while waiting
            if (!s_valid || s_ready) begin
                if (byte_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = byte_fifo.pop_front();
                    s_valid       <= 1'b1;
                    s_rx_byte     <= cur_item.rx;
                    s_frame_start <= cur_item.sof;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            // result transaction: compare with the oldest owed result
            if (m_valid && m_ready) begin
                if (pending.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual status 0x%0h index 0x%0h",
                             $time, m_status, m_payload_index);
                    fail_count++;
                end else begin
                    want = pending.pop_front();
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("frame_kind", 16'(want.kind), 16'(m_frame_kind));
                    check_field("sequence_res", want.seq, m_sequence_res);
                    check_field("payload_index", 16'(want.idx), 16'(m_payload_index));
                    check_field("payload_value", 16'(want.val), 16'(m_payload_value));
                    check_field("last_of_frame", 16'(want.last), 16'(m_last_of_frame));
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
            // watchdog on cycles with no transaction on any channel
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        c8fc_pkg::byte_t v;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at reset register values
        foreach (dir_rows[r]) begin
            add_frame(dir_rows[r].flt, dir_rows[r].right, dir_rows[r].seq, dir_rows[r].fill,
                      dir_rows[r].step, 1'b0, dir_rows[r].cut, dir_rows[r].sof, dir_rows[r].st);
        end
        wait_drained();

        // random registers, no idling on either side for the whole phase
        idle_pct = 0;
        write_reg(c8fc_pkg::REG_START, c8fc_pkg::byte_t'($urandom));
        write_reg(c8fc_pkg::REG_END,   c8fc_pkg::byte_t'($urandom));
        write_reg(c8fc_pkg::REG_LEFT,  c8fc_pkg::byte_t'($urandom));
        write_reg(c8fc_pkg::REG_RIGHT, c8fc_pkg::byte_t'($urandom));
        random_frames(40);
        wait_drained();

        // extremes, plus a write to an index the block has no register for
        idle_pct = IDLE_PCT;
        write_reg(c8fc_pkg::REG_START, 8'h00);
        write_reg(c8fc_pkg::REG_END,   8'hFF);
        write_reg(c8fc_pkg::REG_LEFT,  8'h00);
        write_reg(c8fc_pkg::REG_RIGHT, 8'hFF);
        write_reg(REG_UNUSED,          8'h5A);
        random_frames(20);
        wait_drained();

        // opposite extremes with equal left and right codes
        v = c8fc_pkg::byte_t'($urandom);
        write_reg(c8fc_pkg::REG_START, 8'hFF);
        write_reg(c8fc_pkg::REG_END,   8'h00);
        write_reg(c8fc_pkg::REG_LEFT,  v);
        write_reg(c8fc_pkg::REG_RIGHT, v);
        random_frames(20);
        wait_drained();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
